// File: hdl/wle_pkg.sv
// Shared types and constants for the watermark LRU evictor.
`default_nettype none
package wle_pkg;

  localparam int MEM_W       = 48;
  localparam int CNT_W       = 16;
  localparam int BYTES_W     = 40;
  localparam int FILES_W     = 10;
  localparam int SLOT_PORT_W = 5;
  localparam int MAX_RESULTS = 32;
  localparam int PICK_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [MEM_W-1:0] MEM_HIGH_RST   = 48'd2147483648;
  localparam logic [MEM_W-1:0] MEM_LOW_RST    = 48'd2013265920;
  localparam logic [CNT_W-1:0] FILES_HIGH_RST = 16'd768;
  localparam logic [CNT_W-1:0] FILES_LOW_RST  = 16'd700;

  typedef enum logic [1:0] {
    KIND_REG    = 2'd0,
    KIND_UNREG  = 2'd1,
    KIND_LOAD   = 2'd2,
    KIND_UNLOAD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_MEM_HIGH   = 2'd0,
    CFG_MEM_LOW    = 2'd1,
    CFG_FILES_HIGH = 2'd2,
    CFG_FILES_LOW  = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_REG    = 3'd1,
    CMD_UNREG  = 3'd2,
    CMD_LOAD   = 3'd3,
    CMD_UNLOAD = 3'd4,
    CMD_PICK   = 3'd5,
    CMD_CLEAR  = 3'd6
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [BYTES_W-1:0]   bytes;
    logic [FILES_W-1:0]   files;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: hdl/watermark_lru_evictor.sv
// Top level: slot table chain, totals and collection sequencer.
//
//  channel   handshake        fields
//  request   start / busy     kind, slot, byte_size, file_count
//  result    strobe           evict_valid, evict_slot, last, status,
//                             mem_loaded, files_loaded, collecting
//  config    cfg_we           cfg_index, cfg_data
//
// A request without eviction goes through S_EXEC and S_CHECK to its result. For
// each eviction a search token walks the cell chain one cell per cycle. Reset
// is synchronous; all slots start unregistered. Results cannot be stalled; the
// next request is taken once busy drops.
`default_nettype none
module watermark_lru_evictor #(
  parameter int NUM_SLOTS  = 32,
  parameter int STAMP_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         kind,
  input  wire logic [wle_pkg::SLOT_PORT_W-1:0]    slot,
  input  wire logic [wle_pkg::BYTES_W-1:0]        byte_size,
  input  wire logic [wle_pkg::FILES_W-1:0]        file_count,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [wle_pkg::MEM_W-1:0]          cfg_data,
  output logic                                    strobe,
  output logic                                    evict_valid,
  output logic [wle_pkg::SLOT_PORT_W-1:0]         evict_slot,
  output logic                                    last,
  output logic                                    status,
  output logic [wle_pkg::MEM_W-1:0]               mem_loaded,
  output logic [wle_pkg::CNT_W-1:0]               files_loaded,
  output logic                                    collecting
);
  import wle_pkg::*;

  localparam int SW  = $clog2(NUM_SLOTS);
  localparam int PCW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_CHECK = 5'b00100,
    S_TEST  = 5'b01000,
    S_SCAN  = 5'b10000
  } state_t;

  state_t                     state;
  kind_t                      req_kind;
  logic [SLOT_PORT_W-1:0]     req_slot;
  logic [BYTES_W-1:0]         req_bytes;
  logic [FILES_W-1:0]         req_files;
  logic                       req_status;
  logic                       req_load;
  logic [MEM_W-1:0]           mem_high, mem_low, bl, mem_exp;
  logic [CNT_W-1:0]           files_high, files_low, fl, files_exp;
  logic [STAMP_BITS-1:0]      use_counter, stamp_next;
  logic [PCW-1:0]             pending_count, pc_dec;
  logic                       gc_busy;
  logic [PICK_W-1:0]          n_picks;
  logic                       have_hold;
  logic [SW-1:0]              hold_slot;
  logic                       inject;

  logic                       ch_act   [NUM_SLOTS+1];
  logic                       ch_found [NUM_SLOTS+1];
  logic [STAMP_BITS-1:0]      ch_age   [NUM_SLOTS+1];
  logic [SW-1:0]              ch_slot  [NUM_SLOTS+1];
  logic [BYTES_W-1:0]         ch_bytes [NUM_SLOTS+1];
  logic [FILES_W-1:0]         ch_files [NUM_SLOTS+1];

  logic                       c_used    [NUM_SLOTS];
  logic                       c_loaded  [NUM_SLOTS];
  logic                       c_pending [NUM_SLOTS];
  logic [BYTES_W-1:0]         c_bytes   [NUM_SLOTS];
  logic [FILES_W-1:0]         c_files   [NUM_SLOTS];

  cell_cmd_t                  cmd;
  logic [NUM_SLOTS-1:0]       sel;
  logic [SW-1:0]              rd_slot;
  logic                       e_used, e_loaded, e_pending;
  logic [BYTES_W-1:0]         e_bytes;
  logic [FILES_W-1:0]         e_files;
  logic                       slot_ok, valid_op, tail_pick;
  logic [MEM_W-1:0]           bl_sub, bl_add, mexp_sub;
  logic [CNT_W-1:0]           fl_sub, fl_add, fexp_sub;
  logic [MEM_W:0]             bl_sum;
  logic [CNT_W:0]             fl_sum;

  assign ch_act[0]   = inject;
  assign ch_found[0] = 1'b0;
  assign ch_age[0]   = '0;
  assign ch_slot[0]  = '0;
  assign ch_bytes[0] = '0;
  assign ch_files[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    wle_cell #(.SW(SW), .STAMP_BITS(STAMP_BITS), .IDX(i)) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .sel(sel[i]),
      .stamp_in(stamp_next), .use_counter(use_counter),
      .used(c_used[i]), .loaded(c_loaded[i]), .pending(c_pending[i]),
      .bytes(c_bytes[i]), .files(c_files[i]),
      .in_act(ch_act[i]), .in_found(ch_found[i]), .in_age(ch_age[i]),
      .in_slot(ch_slot[i]), .in_bytes(ch_bytes[i]), .in_files(ch_files[i]),
      .out_act(ch_act[i+1]), .out_found(ch_found[i+1]), .out_age(ch_age[i+1]),
      .out_slot(ch_slot[i+1]), .out_bytes(ch_bytes[i+1]),
      .out_files(ch_files[i+1])
    );
  end

  assign busy       = (state != S_IDLE);
  assign stamp_next = use_counter + STAMP_BITS'(1);
  assign tail_pick  = (state == S_SCAN) && ch_act[NUM_SLOTS] && ch_found[NUM_SLOTS];
  assign rd_slot    = (state == S_SCAN) ? ch_slot[NUM_SLOTS] : SW'(req_slot);
  assign e_used     = c_used[rd_slot];
  assign e_loaded   = c_loaded[rd_slot];
  assign e_pending  = c_pending[rd_slot];
  assign e_bytes    = c_bytes[rd_slot];
  assign e_files    = c_files[rd_slot];
  assign slot_ok    = (32'(req_slot) < NUM_SLOTS);
  assign valid_op   = slot_ok && (req_kind == KIND_REG || e_used);

  assign bl_sub = (bl > MEM_W'(e_bytes)) ? bl - MEM_W'(e_bytes) : '0;
  assign fl_sub = (fl > CNT_W'(e_files)) ? fl - CNT_W'(e_files) : '0;
  assign bl_sum = {1'b0, bl} + (MEM_W+1)'(e_bytes);
  assign fl_sum = {1'b0, fl} + (CNT_W+1)'(e_files);
  assign bl_add = bl_sum[MEM_W] ? '1 : bl_sum[MEM_W-1:0];
  assign fl_add = fl_sum[CNT_W] ? '1 : fl_sum[CNT_W-1:0];
  assign mexp_sub = (mem_exp > MEM_W'(ch_bytes[NUM_SLOTS]))
                  ? mem_exp - MEM_W'(ch_bytes[NUM_SLOTS]) : '0;
  assign fexp_sub = (files_exp > CNT_W'(ch_files[NUM_SLOTS]))
                  ? files_exp - CNT_W'(ch_files[NUM_SLOTS]) : '0;
  assign pc_dec = (pending_count != '0) ? pending_count - PCW'(1) : '0;

  always_comb begin
    cmd.op    = CMD_NONE;
    cmd.bytes = req_bytes;
    cmd.files = req_files;
    sel       = '0;
    sel[rd_slot] = 1'b1;
    unique case (state)
      S_EXEC: begin
        if (valid_op) begin
          unique case (req_kind)
            KIND_REG:    cmd.op = CMD_REG;
            KIND_UNREG:  cmd.op = CMD_UNREG;
            KIND_LOAD:   cmd.op = CMD_LOAD;
            KIND_UNLOAD: cmd.op = CMD_UNLOAD;
            default:     cmd.op = CMD_NONE;
          endcase
        end
      end
      S_CHECK: cmd.op = CMD_CLEAR;
      S_SCAN:  cmd.op = tail_pick ? CMD_PICK : CMD_NONE;
      default: cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mem_high      <= MEM_HIGH_RST;
      mem_low       <= MEM_LOW_RST;
      files_high    <= FILES_HIGH_RST;
      files_low     <= FILES_LOW_RST;
      bl            <= '0;
      fl            <= '0;
      use_counter   <= '0;
      pending_count <= '0;
      gc_busy       <= 1'b0;
      inject        <= 1'b0;
      strobe        <= 1'b0;
      have_hold     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      inject <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_MEM_HIGH:   mem_high   <= cfg_data;
          CFG_MEM_LOW:    mem_low    <= cfg_data;
          CFG_FILES_HIGH: files_high <= cfg_data[CNT_W-1:0];
          CFG_FILES_LOW:  files_low  <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_kind  <= kind_t'(kind);
            req_slot  <= slot;
            req_bytes <= byte_size;
            req_files <= file_count;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          req_status <= !valid_op;
          req_load   <= valid_op && (req_kind == KIND_LOAD);
          if (valid_op) begin
            if (req_kind == KIND_LOAD) begin
              if (!e_loaded) begin
                bl <= bl_add;
                fl <= fl_add;
              end
              use_counter <= stamp_next;
            end else begin
              if (e_loaded) begin
                bl <= bl_sub;
                fl <= fl_sub;
              end
              if (e_pending) begin
                pending_count <= pc_dec;
                if (pc_dec == '0) begin
                  gc_busy <= 1'b0;
                end
              end
            end
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (req_load && !gc_busy && (bl > mem_high || fl > files_high)) begin
            mem_exp   <= bl;
            files_exp <= fl;
            n_picks   <= '0;
            have_hold <= 1'b0;
            state     <= S_TEST;
          end else begin
            strobe       <= 1'b1;
            evict_valid  <= 1'b0;
            evict_slot   <= '0;
            last         <= 1'b1;
            status       <= req_status;
            mem_loaded   <= bl;
            files_loaded <= fl;
            collecting   <= gc_busy;
            state        <= S_IDLE;
          end
        end
        S_TEST: begin
          if (32'(n_picks) < MAX_RESULTS &&
              (files_exp > files_low || mem_exp > mem_low)) begin
            inject <= 1'b1;
            state  <= S_SCAN;
          end else begin
            strobe       <= 1'b1;
            evict_valid  <= have_hold;
            evict_slot   <= have_hold ? SLOT_PORT_W'(hold_slot) : '0;
            last         <= 1'b1;
            status       <= 1'b0;
            mem_loaded   <= bl;
            files_loaded <= fl;
            collecting   <= gc_busy;
            state        <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (tail_pick) begin
            if (!e_pending) begin
              pending_count <= pending_count + PCW'(1);
            end
            gc_busy   <= 1'b1;
            mem_exp   <= mexp_sub;
            files_exp <= fexp_sub;
            n_picks   <= n_picks + PICK_W'(1);
            if (have_hold) begin
              strobe       <= 1'b1;
              evict_valid  <= 1'b1;
              evict_slot   <= SLOT_PORT_W'(hold_slot);
              last         <= 1'b0;
              status       <= 1'b0;
              mem_loaded   <= bl;
              files_loaded <= fl;
              collecting   <= 1'b1;
            end
            hold_slot <= ch_slot[NUM_SLOTS];
            have_hold <= 1'b1;
            state     <= S_TEST;
          end else if (ch_act[NUM_SLOTS]) begin
            strobe       <= 1'b1;
            evict_valid  <= have_hold;
            evict_slot   <= have_hold ? SLOT_PORT_W'(hold_slot) : '0;
            last         <= 1'b1;
            status       <= 1'b0;
            mem_loaded   <= bl;
            files_loaded <= fl;
            collecting   <= gc_busy;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy) else $error("non-final result while idle");

  a_evict_collecting: assert property (@(posedge clk) disable iff (rst)
    strobe && evict_valid |-> collecting) else $error("eviction without collection");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");

  a_gc_count: assert property (@(posedge clk) disable iff (rst)
    gc_busy == (pending_count != '0)) else $error("pending count and gc flag disagree");

endmodule
`default_nettype wire

// File: hdl/wle_cell.sv
// One table slot plus one registered stage of the oldest-entry search chain.
`default_nettype none
module wle_cell #(
  parameter int SW         = 5,
  parameter int STAMP_BITS = 32,
  parameter int IDX        = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire wle_pkg::cell_cmd_t           cmd,
  input  wire logic                         sel,
  input  wire logic [STAMP_BITS-1:0]        stamp_in,
  input  wire logic [STAMP_BITS-1:0]        use_counter,
  output logic                              used,
  output logic                              loaded,
  output logic                              pending,
  output logic [wle_pkg::BYTES_W-1:0]       bytes,
  output logic [wle_pkg::FILES_W-1:0]       files,
  input  wire logic                         in_act,
  input  wire logic                         in_found,
  input  wire logic [STAMP_BITS-1:0]        in_age,
  input  wire logic [SW-1:0]                in_slot,
  input  wire logic [wle_pkg::BYTES_W-1:0]  in_bytes,
  input  wire logic [wle_pkg::FILES_W-1:0]  in_files,
  output logic                              out_act,
  output logic                              out_found,
  output logic [STAMP_BITS-1:0]             out_age,
  output logic [SW-1:0]                     out_slot,
  output logic [wle_pkg::BYTES_W-1:0]       out_bytes,
  output logic [wle_pkg::FILES_W-1:0]       out_files
);
  import wle_pkg::*;

  logic                  taken;
  logic [STAMP_BITS-1:0] stamp;
  logic [STAMP_BITS-1:0] age;
  logic                  take;

  assign take = used && loaded && !taken && (!in_found || (age > in_age));

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      loaded  <= 1'b0;
      pending <= 1'b0;
      taken   <= 1'b0;
      out_act <= 1'b0;
    end else begin
      out_act <= in_act;
      if (cmd.op == CMD_CLEAR) begin
        taken <= 1'b0;
      end
      if (sel) begin
        unique case (cmd.op)
          CMD_REG: begin
            used    <= 1'b1;
            loaded  <= 1'b0;
            pending <= 1'b0;
          end
          CMD_UNREG: begin
            used    <= 1'b0;
            loaded  <= 1'b0;
            pending <= 1'b0;
          end
          CMD_LOAD: begin
            loaded <= 1'b1;
          end
          CMD_UNLOAD: begin
            loaded  <= 1'b0;
            pending <= 1'b0;
          end
          CMD_PICK: begin
            taken   <= 1'b1;
            pending <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    age <= use_counter - stamp;
    if (sel && cmd.op == CMD_REG) begin
      bytes <= cmd.bytes;
      files <= cmd.files;
      stamp <= '0;
    end else if (sel && cmd.op == CMD_LOAD) begin
      stamp <= stamp_in;
    end
    if (take) begin
      out_found <= 1'b1;
      out_age   <= age;
      out_slot  <= SW'(IDX);
      out_bytes <= bytes;
      out_files <= files;
    end else begin
      out_found <= in_found;
      out_age   <= in_age;
      out_slot  <= in_slot;
      out_bytes <= in_bytes;
      out_files <= in_files;
    end
  end

endmodule
`default_nettype wire
